// File: rtl/interrupt_dispatch_unit_top_assert.svh
// Assertion macros shared by the checker of the interrupt dispatch unit
`ifndef INTERRUPT_DISPATCH_UNIT_TOP_ASSERT_SVH
`define INTERRUPT_DISPATCH_UNIT_TOP_ASSERT_SVH

// Checked on every rising i_clk edge outside reset
`define IDU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising i_clk edge, reset included
`define IDU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/idu_pkg.sv
// Types, codes and helper functions of the interrupt dispatch unit
package idu_pkg;

    localparam int unsigned NumSrc = 5;

    typedef enum logic [2:0] {
        OP_PLAIN     = 3'd0,
        OP_BOUNDARY  = 3'd1,
        OP_EI        = 3'd2,
        OP_DI        = 3'd3,
        OP_HALT      = 3'd4,
        OP_WR_ENABLE = 3'd5,
        OP_WR_FLAGS  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_PUSH  = 2'd2,
        PH_SETPC = 2'd3
    } t_phase;

    localparam logic [6:0] VectorBase = 7'h40;

    typedef struct packed {
        logic [2:0]        operation;
        logic [NumSrc-1:0] write_data;
        logic [NumSrc-1:0] request_lines;
        logic [15:0]       stack_pointer;
        logic [15:0]       program_counter;
        logic              preloaded;
    } t_in_item;

    typedef struct packed {
        logic              dispatch_busy;
        logic              push_valid;
        logic [15:0]       push_address;
        logic [15:0]       push_data;
        logic              pc_load_valid;
        logic [6:0]        pc_load_value;
        logic              halted;
        logic              master_enable;
        logic [NumSrc-1:0] pending_flags;
        logic [NumSrc-1:0] enable_flags;
        logic              repeat_fetch;
    } t_out_item;

    // Index of the lowest set bit, zero when none is set
    function automatic logic [2:0] lowest_src(input logic [NumSrc-1:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = NumSrc - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/idu_if.sv
// Valid/ready channel interfaces for items in and results out
interface idu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [4:0]  write_data;
    logic [4:0]  request_lines;
    logic [15:0] stack_pointer;
    logic [15:0] program_counter;
    logic        preloaded;

    modport source (
        output valid, operation, write_data, request_lines,
               stack_pointer, program_counter, preloaded,
        input  ready
    );
    modport sink (
        input  valid, operation, write_data, request_lines,
               stack_pointer, program_counter, preloaded,
        output ready
    );
endinterface

interface idu_out_if;
    logic        valid;
    logic        ready;
    logic        dispatch_busy;
    logic        push_valid;
    logic [15:0] push_address;
    logic [15:0] push_data;
    logic        pc_load_valid;
    logic [6:0]  pc_load_value;
    logic        halted;
    logic        master_enable;
    logic [4:0]  pending_flags;
    logic [4:0]  enable_flags;
    logic        repeat_fetch;

    modport source (
        output valid, dispatch_busy, push_valid, push_address, push_data,
               pc_load_valid, pc_load_value, halted, master_enable,
               pending_flags, enable_flags, repeat_fetch,
        input  ready
    );
    modport sink (
        input  valid, dispatch_busy, push_valid, push_address, push_data,
               pc_load_valid, pc_load_value, halted, master_enable,
               pending_flags, enable_flags, repeat_fetch,
        output ready
    );
endinterface

// File: rtl/idu_in_stage.sv
// Input register stage: captures one item and holds it until the core takes it
module idu_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    idu_in_if.sink             i_in,
    input  logic               i_take,
    output logic               o_valid,
    output idu_pkg::t_in_item  o_item
);

    logic              r_valid;
    logic              n_valid;
    idu_pkg::t_in_item r_item;
    logic              load;

    // Accept whenever the held item leaves this cycle or nothing is held
    assign i_in.ready = !r_valid || i_take;
    assign load       = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.operation       <= i_in.operation;
            r_item.write_data      <= i_in.write_data;
            r_item.request_lines   <= i_in.request_lines;
            r_item.stack_pointer   <= i_in.stack_pointer;
            r_item.program_counter <= i_in.program_counter;
            r_item.preloaded       <= i_in.preloaded;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/idu_core.sv
// Interrupt state, EI delay, halt wake and the dispatch sequencer
module idu_core #(
    parameter int unsigned EI_DELAY_CYCLES = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  idu_pkg::t_in_item  i_item,
    output idu_pkg::t_out_item o_result
);

    localparam int unsigned CntW = $clog2(EI_DELAY_CYCLES + 1);

    logic                         r_ime,   n_ime;
    logic [CntW-1:0]              r_ei,    n_ei;
    logic                         r_halt,  n_halt;
    logic [idu_pkg::NumSrc-1:0]   r_flag,  n_flag;
    logic [idu_pkg::NumSrc-1:0]   r_en,    n_en;
    idu_pkg::t_phase              r_phase, n_phase;
    logic                         r_cnt,   n_cnt;
    logic [2:0]                   r_src,   n_src;
    logic [15:0]                  r_ret,   n_ret;

    logic [idu_pkg::NumSrc-1:0]   pending;
    logic                         ime_was;
    idu_pkg::t_out_item           res;

    always_comb begin
        n_ime   = r_ime;
        n_ei    = r_ei;
        n_halt  = r_halt;
        n_flag  = r_flag;
        n_en    = r_en;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_src   = r_src;
        n_ret   = r_ret;
        pending = '0;
        ime_was = 1'b0;
        res     = '0;

        // EI countdown ticks before anything else
        if (r_ei != '0) begin
            n_ei = r_ei - CntW'(1);
            if (n_ei == '0) begin
                n_ime = 1'b1;
            end
        end

        if (r_phase != idu_pkg::PH_IDLE) begin
            // Operations are dropped while dispatching; requests still latch
            res.dispatch_busy = 1'b1;
            n_flag = r_flag | i_item.request_lines;
            case (r_phase)
                idu_pkg::PH_WAIT: begin
                    n_cnt = !r_cnt;
                    if (r_cnt) begin
                        n_phase = idu_pkg::PH_PUSH;
                    end
                end
                idu_pkg::PH_PUSH: begin
                    n_cnt = !r_cnt;
                    if (r_cnt) begin
                        res.push_valid   = 1'b1;
                        res.push_address = i_item.stack_pointer - 16'd2;
                        res.push_data    = r_ret;
                        n_phase          = idu_pkg::PH_SETPC;
                    end
                end
                idu_pkg::PH_SETPC: begin
                    res.pc_load_valid = 1'b1;
                    res.pc_load_value = idu_pkg::VectorBase + {1'b0, r_src, 3'b000};
                    n_phase           = idu_pkg::PH_IDLE;
                    n_cnt             = 1'b0;
                end
                default: begin
                end
            endcase
        end else begin
            case (i_item.operation)
                idu_pkg::OP_EI:        n_ei = CntW'(EI_DELAY_CYCLES);
                idu_pkg::OP_DI: begin
                    n_ime = 1'b0;
                    n_ei  = '0;
                end
                idu_pkg::OP_HALT:      n_halt = 1'b1;
                idu_pkg::OP_WR_ENABLE: n_en   = i_item.write_data;
                idu_pkg::OP_WR_FLAGS:  n_flag = i_item.write_data;
                default: begin
                end
            endcase
            n_flag  = n_flag | i_item.request_lines;
            pending = n_en & n_flag;
            ime_was = n_ime;

            if (i_item.operation == idu_pkg::OP_BOUNDARY && pending != '0 && ime_was) begin
                n_ime   = 1'b0;
                n_src   = idu_pkg::lowest_src(pending);
                n_flag  = n_flag & ~(idu_pkg::NumSrc'(1) << n_src);
                n_ret   = i_item.program_counter - {15'd0, i_item.preloaded};
                n_phase = idu_pkg::PH_WAIT;
                n_cnt   = 1'b0;
                res.dispatch_busy = 1'b1;
            end

            // Wake from HALT; with IME clear this is the halt bug
            if (pending != '0 && n_halt) begin
                n_halt           = 1'b0;
                res.repeat_fetch = !ime_was;
            end
        end

        res.halted        = n_halt;
        res.master_enable = n_ime;
        res.pending_flags = n_flag;
        res.enable_flags  = n_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ime   <= 1'b0;
            r_ei    <= '0;
            r_halt  <= 1'b0;
            r_flag  <= '0;
            r_en    <= '0;
            r_phase <= idu_pkg::PH_IDLE;
            r_cnt   <= 1'b0;
            r_src   <= 3'd0;
            r_ret   <= 16'd0;
        end else if (i_step) begin
            r_ime   <= n_ime;
            r_ei    <= n_ei;
            r_halt  <= n_halt;
            r_flag  <= n_flag;
            r_en    <= n_en;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_src   <= n_src;
            r_ret   <= n_ret;
        end
    end

    assign o_result = res;

endmodule

// File: rtl/interrupt_dispatch_unit_top.sv
// Top level of the interrupt dispatch unit: input stage, core and result register
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+------------------------------------------
//   i_in     | in  | valid/ready  | operation, write_data, request_lines,
//            |     |              | stack_pointer, program_counter, preloaded
//   o_out    | out | valid/ready  | busy, push, pc load, halted, IME, IF, IE,
//            |     |              | repeat_fetch
//
// One item per clock while o_out is not stalled; a result passes through the input
// register, then the result register after the single-pass core.
// The state update and the result register advance together, so every item
// yields exactly one result. A stalled o_out holds the result and, once the
// input register is full, drops i_in.ready. Reset clears all interrupt state.
module interrupt_dispatch_unit_top #(
    parameter int unsigned EI_DELAY_CYCLES = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    idu_in_if.sink    i_in,
    idu_out_if.source o_out
);

    logic               in_valid;
    idu_pkg::t_in_item  in_item;
    idu_pkg::t_out_item core_res;
    logic               advance;
    logic               step;

    logic               r_out_valid;
    logic               n_out_valid;
    idu_pkg::t_out_item r_out_item;

    assign advance = !r_out_valid || o_out.ready;
    assign step    = in_valid && advance;

    idu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    idu_core #(
        .EI_DELAY_CYCLES (EI_DELAY_CYCLES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (in_item),
        .o_result (core_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= core_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.dispatch_busy = r_out_item.dispatch_busy;
    assign o_out.push_valid    = r_out_item.push_valid;
    assign o_out.push_address  = r_out_item.push_address;
    assign o_out.push_data     = r_out_item.push_data;
    assign o_out.pc_load_valid = r_out_item.pc_load_valid;
    assign o_out.pc_load_value = r_out_item.pc_load_value;
    assign o_out.halted        = r_out_item.halted;
    assign o_out.master_enable = r_out_item.master_enable;
    assign o_out.pending_flags = r_out_item.pending_flags;
    assign o_out.enable_flags  = r_out_item.enable_flags;
    assign o_out.repeat_fetch  = r_out_item.repeat_fetch;

endmodule

// File: rtl/idu_checker.sv
// Port-level checker for the interrupt dispatch unit, bound to the top level
`include "interrupt_dispatch_unit_top_assert.svh"

module idu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_dispatch_busy,
    input logic        i_push_valid,
    input logic        i_pc_load_valid,
    input logic [6:0]  i_pc_load_value,
    input logic [15:0] i_push_data,
    input logic        i_halted,
    input logic        i_master_enable,
    input logic        i_repeat_fetch
);

    // A stalled result holds
    `IDU_ASSERT(a_out_hold,
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_push_data) && $stable(i_pc_load_value),
        "stalled result changed")

    // Nothing comes out in the cycle after reset
    `IDU_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result valid right after reset")

    // Push and vector load are separate busy cycles
    `IDU_ASSERT(a_push_busy, i_out_valid && i_push_valid |-> i_dispatch_busy && !i_pc_load_valid, "push outside a busy cycle")

    // Vector load targets one of the five vectors
    `IDU_ASSERT(a_vector,
        i_out_valid && i_pc_load_valid |->
            (i_pc_load_value == 7'h40 || i_pc_load_value == 7'h48 ||
             i_pc_load_value == 7'h50 || i_pc_load_value == 7'h58 ||
             i_pc_load_value == 7'h60),
        "bad vector load")

    // Halt bug only on a wake with IME clear
    `IDU_ASSERT(a_halt_bug,
        i_out_valid && i_repeat_fetch |-> !i_halted && !i_master_enable && !i_dispatch_busy,
        "repeat fetch without halt wake")

endmodule

bind interrupt_dispatch_unit_top idu_checker u_idu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_dispatch_busy (o_out.dispatch_busy),
    .i_push_valid    (o_out.push_valid),
    .i_pc_load_valid (o_out.pc_load_valid),
    .i_pc_load_value (o_out.pc_load_value),
    .i_push_data     (o_out.push_data),
    .i_halted        (o_out.halted),
    .i_master_enable (o_out.master_enable),
    .i_repeat_fetch  (o_out.repeat_fetch)
);

// File: tb/tb_interrupt_dispatch_unit_top.sv
// Self-checking testbench for the interrupt dispatch unit, with directed and random cycles
`timescale 1ns / 100ps

module tb_interrupt_dispatch_unit_top;

    localparam int unsigned EiDelay     = 2;
    localparam int unsigned RandomItems = 1950;
    localparam int unsigned CycleLimit  = 200000;
    localparam logic [2:0]  OpUnused    = 3'd7;

    logic clk;
    logic rst_n;

    idu_in_if  in_ch ();
    idu_out_if out_ch ();

    interrupt_dispatch_unit_top #(
        .EI_DELAY_CYCLES(EiDelay)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Shadow of the interrupt state, advanced once per accepted item
    logic            irq_ime;
    logic [1:0]      irq_ei_count;
    logic            irq_halted;
    logic [4:0]      irq_flags;
    logic [4:0]      irq_enables;
    idu_pkg::t_phase irq_phase;
    logic            irq_phase_half;
    logic [2:0]      irq_source;
    logic [15:0]     irq_return_pc;

    idu_pkg::t_out_item expected_status[$];
    int unsigned        mismatch_count;
    int unsigned        live_items;
    int unsigned        cycle_count;
    bit                 no_idle;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic idu_pkg::t_out_item step_irq_state(input idu_pkg::t_in_item it);
        idu_pkg::t_out_item r;
        logic [4:0]         pending;
        logic               ime_before;
        r = '0;
        if (irq_ei_count != 2'd0) begin
            irq_ei_count = irq_ei_count - 2'd1;
            if (irq_ei_count == 2'd0) begin
                irq_ime = 1'b1;
            end
        end
        if (irq_phase != idu_pkg::PH_IDLE) begin
            // operation ignored while dispatching; requests still land
            r.dispatch_busy = 1'b1;
            irq_flags = irq_flags | it.request_lines;
            case (irq_phase)
                idu_pkg::PH_WAIT: begin
                    if (!irq_phase_half) begin
                        irq_phase_half = 1'b1;
                    end else begin
                        irq_phase_half = 1'b0;
                        irq_phase = idu_pkg::PH_PUSH;
                    end
                end
                idu_pkg::PH_PUSH: begin
                    if (!irq_phase_half) begin
                        irq_phase_half = 1'b1;
                    end else begin
                        irq_phase_half = 1'b0;
                        r.push_valid = 1'b1;
                        r.push_address = it.stack_pointer - 16'd2;
                        r.push_data = irq_return_pc;
                        irq_phase = idu_pkg::PH_SETPC;
                    end
                end
                default: begin
                    r.pc_load_valid = 1'b1;
                    r.pc_load_value = idu_pkg::VectorBase + {1'b0, irq_source, 3'b000};
                    irq_phase = idu_pkg::PH_IDLE;
                    irq_phase_half = 1'b0;
                end
            endcase
        end else begin
            case (it.operation)
                idu_pkg::OP_EI:        irq_ei_count = 2'(EiDelay);
                idu_pkg::OP_DI: begin
                    irq_ime = 1'b0;
                    irq_ei_count = 2'd0;
                end
                idu_pkg::OP_HALT:      irq_halted = 1'b1;
                idu_pkg::OP_WR_ENABLE: irq_enables = it.write_data;
                idu_pkg::OP_WR_FLAGS:  irq_flags = it.write_data;
                default: ;
            endcase
            irq_flags = irq_flags | it.request_lines;
            pending = irq_enables & irq_flags;
            ime_before = irq_ime;
            if (it.operation == idu_pkg::OP_BOUNDARY && pending != 5'd0 && ime_before) begin
                irq_ime = 1'b0;
                for (int i = 4; i >= 0; i--) begin
                    if (pending[i]) begin
                        irq_source = 3'(i);
                    end
                end
                irq_flags[irq_source] = 1'b0;
                irq_return_pc = it.program_counter - 16'(it.preloaded);
                irq_phase = idu_pkg::PH_WAIT;
                irq_phase_half = 1'b0;
                r.dispatch_busy = 1'b1;
            end
            if (pending != 5'd0 && irq_halted) begin
                irq_halted = 1'b0;
                r.repeat_fetch = !ime_before;
            end
        end
        r.halted = irq_halted;
        r.master_enable = irq_ime;
        r.pending_flags = irq_flags;
        r.enable_flags = irq_enables;
        return r;
    endfunction

    // Drive one item after a random gap and predict it once it is taken
    task automatic send_item(input idu_pkg::t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.operation       <= it.operation;
        in_ch.write_data      <= it.write_data;
        in_ch.request_lines   <= it.request_lines;
        in_ch.stack_pointer   <= it.stack_pointer;
        in_ch.program_counter <= it.program_counter;
        in_ch.preloaded       <= it.preloaded;
        do @(posedge clk); while (!in_ch.ready);
        live_items++;
        expected_status.push_back(step_irq_state(it));
    endtask

    task automatic drive_op(input logic [2:0] op, input logic [4:0] wdata,
                            input logic [4:0] req, input logic [15:0] sp,
                            input logic [15:0] pc, input logic pre);
        idu_pkg::t_in_item it;
        it.operation       = op;
        it.write_data      = wdata;
        it.request_lines   = req;
        it.stack_pointer   = sp;
        it.program_counter = pc;
        it.preloaded       = pre;
        send_item(it);
    endtask

    task automatic send_rand(input logic [2:0] op, input logic [4:0] req);
        drive_op(op, 5'($urandom), req, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    function automatic logic [4:0] sparse_req();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
    endfunction

    task automatic test_register_writes();
        drive_op(idu_pkg::OP_WR_ENABLE, 5'h1F, 5'h00, 16'h0000, 16'h0000, 1'b0);
        // requests OR in on top of the written flags
        drive_op(idu_pkg::OP_WR_FLAGS, 5'b00101, 5'b11010, 16'hFFFF, 16'hFFFF, 1'b1);
        drive_op(OpUnused, 5'h1F, 5'h00, 16'h1234, 16'h5678, 1'b0);
        drive_op(idu_pkg::OP_WR_FLAGS, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
    endtask

    task automatic test_ei_di();
        drive_op(idu_pkg::OP_EI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_EI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        // cancel the pending enable
        drive_op(idu_pkg::OP_DI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_EI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_PLAIN, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_PLAIN, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
    endtask

    task automatic test_dispatch_sequence();
        // return address wraps below zero, push address wraps too
        drive_op(idu_pkg::OP_BOUNDARY, 5'h00, 5'b10000, 16'h0000, 16'h0000, 1'b1);
        drive_op(idu_pkg::OP_DI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_HALT, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_WR_FLAGS, 5'h1F, 5'b00001, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_EI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_PLAIN, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
    endtask

    task automatic test_halt_bug();
        // source already pending with IME clear: wake at once and repeat the fetch
        drive_op(idu_pkg::OP_HALT, 5'h00, 5'h00, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic test_halt_wake();
        drive_op(idu_pkg::OP_WR_FLAGS, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_EI, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_HALT, 5'h00, 5'h00, 16'h0000, 16'h0000, 1'b0);
        // wake on a plain cycle; dispatch waits for the boundary
        drive_op(idu_pkg::OP_PLAIN, 5'h00, 5'b00100, 16'h0000, 16'h0000, 1'b0);
        drive_op(idu_pkg::OP_BOUNDARY, 5'h00, 5'h00, 16'hFFFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int          scenario;
        int          n;
        start = live_items;
        while (live_items - start < RandomItems) begin
            no_idle = ($urandom_range(0, 3) == 0);
            scenario = $urandom_range(0, 9);
            if (scenario < 5) begin
                // arm, enable, then take an interrupt at a boundary
                send_rand(idu_pkg::OP_WR_ENABLE, sparse_req());
                send_rand(idu_pkg::OP_EI, sparse_req());
                n = $urandom_range(1, 4);
                repeat (n) send_rand($urandom_range(0, 1) ? idu_pkg::OP_PLAIN
                                                          : idu_pkg::OP_BOUNDARY,
                                     sparse_req());
                send_rand(idu_pkg::OP_BOUNDARY, 5'(1 << $urandom_range(0, 4)));
                repeat (5) send_rand(3'($urandom_range(0, 7)), sparse_req());
            end else if (scenario < 7) begin
                send_rand($urandom_range(0, 1) ? idu_pkg::OP_DI : idu_pkg::OP_EI, 5'd0);
                send_rand(idu_pkg::OP_HALT, sparse_req());
                n = $urandom_range(1, 6);
                repeat (n) send_rand(idu_pkg::OP_PLAIN, sparse_req());
                send_rand(idu_pkg::OP_BOUNDARY, sparse_req());
            end else if (scenario < 8) begin
                send_rand(idu_pkg::OP_WR_FLAGS, 5'($urandom));
                send_rand(idu_pkg::OP_BOUNDARY, sparse_req());
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) send_rand(3'($urandom_range(0, 7)), 5'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        idu_pkg::t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_status.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got busy=%0b flags=%0h",
                         $time, out_ch.dispatch_busy, out_ch.pending_flags);
            end else begin
                want = expected_status.pop_front();
                check_field("dispatch_busy", 16'(want.dispatch_busy),
                            16'(out_ch.dispatch_busy));
                check_field("push_valid", 16'(want.push_valid), 16'(out_ch.push_valid));
                check_field("push_address", want.push_address, out_ch.push_address);
                check_field("push_data", want.push_data, out_ch.push_data);
                check_field("pc_load_valid", 16'(want.pc_load_valid),
                            16'(out_ch.pc_load_valid));
                check_field("pc_load_value", 16'(want.pc_load_value),
                            16'(out_ch.pc_load_value));
                check_field("halted", 16'(want.halted), 16'(out_ch.halted));
                check_field("master_enable", 16'(want.master_enable),
                            16'(out_ch.master_enable));
                check_field("pending_flags", 16'(want.pending_flags),
                            16'(out_ch.pending_flags));
                check_field("enable_flags", 16'(want.enable_flags),
                            16'(out_ch.enable_flags));
                check_field("repeat_fetch", 16'(want.repeat_fetch),
                            16'(out_ch.repeat_fetch));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each result
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && out_ch.valid));
        end
    end

    initial begin
        irq_ime        = 1'b0;
        irq_ei_count   = 2'd0;
        irq_halted     = 1'b0;
        irq_flags      = 5'd0;
        irq_enables    = 5'd0;
        irq_phase      = idu_pkg::PH_IDLE;
        irq_phase_half = 1'b0;
        irq_source     = 3'd0;
        irq_return_pc  = 16'd0;
        mismatch_count = 0;
        live_items     = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.operation       <= idu_pkg::OP_PLAIN;
        in_ch.write_data      <= 5'd0;
        in_ch.request_lines   <= 5'd0;
        in_ch.stack_pointer   <= 16'd0;
        in_ch.program_counter <= 16'd0;
        in_ch.preloaded       <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_register_writes();
        test_ei_di();
        test_dispatch_sequence();
        test_halt_bug();
        test_halt_wake();
        test_random_traffic();

        in_ch.valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/idu_pkg.sv
rtl/idu_if.sv
rtl/idu_in_stage.sv
rtl/idu_core.sv
rtl/interrupt_dispatch_unit_top.sv
rtl/idu_checker.sv
tb/tb_interrupt_dispatch_unit_top.sv
